[sv/fsavs_pkg.sv]
// ----------------------------------------------------------------------------
// fsavs_pkg
// Shared types and constants for the four-state arc scorer.
// ----------------------------------------------------------------------------
package fsavs_pkg;

  localparam int MAX_SEGMENTS_DEF = 65536;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MIN_DUR  = 2'd0;
  localparam logic [1:0] CFG_MAX_DUR  = 2'd1;
  localparam logic [1:0] CFG_MIN_MEAN = 2'd2;

  localparam logic [31:0] MIN_DUR_RST  = 32'd0;
  localparam logic [31:0] MAX_DUR_RST  = 32'hFFFF_FFFF;
  localparam logic [12:0] MIN_MEAN_RST = 13'd1147;

  // Transition weights in Q.12, indexed [previous state][next state].
  localparam logic signed [11:0] TRANS [4][4] = '{
    '{-12'sd246,  12'sd901,  -12'sd82,   -12'sd1966},
    '{-12'sd1966, 12'sd82,   12'sd983,   -12'sd410},
    '{-12'sd1966, -12'sd1966, 12'sd492,  12'sd1393},
    '{-12'sd1966, -12'sd1966, -12'sd1966, -12'sd328}
  };

  // Emission sums are biased by 8192 whole steps plus the rounding half.
  localparam logic signed [23:0] EMIT_BIAS = 24'sd819250;
  localparam logic [15:0] RECIP100 = 16'd41943;     // floor(2^22 / 100)
  localparam logic [22:0] RECIP3125 = 23'd5497558;  // floor(2^34 / 3125)
  localparam logic [11:0] PEN_CAP = 12'd2662;

  localparam int DIV_BITS = 13;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_EMIT   = 8'b0000_0010,
    S_SCAN   = 8'b0000_0100,
    S_COMMIT = 8'b0000_1000,
    S_CHECK  = 8'b0001_0000,
    S_TEST   = 8'b0010_0000,
    S_DIV    = 8'b0100_0000,
    S_FIN    = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic       load;
    logic       scan;
    logic [1:0] idx;
    logic       commit;
    logic       check;
    logic       div_step;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic pass;
  } status_t;

endpackage

[sv/four_state_arc_viterbi_scorer.sv]
// ----------------------------------------------------------------------------
// four_state_arc_viterbi_scorer
// Max-sum scoring of transcript segments over four arc states, one arc out.
// ----------------------------------------------------------------------------
//  Channel  Handshake              Carries
//  in       in_valid / in_ready    one segment: times, six Q.12 features, cue
//  out      out_valid / out_ready  one qualifying arc
//  cfg      cfg_valid / cfg_ready  register index and write data
//
// A segment passes an emission and gap pipe, a cell update that takes one
// state at a time, commit and checks, and then, when an arc qualifies, a
// 13-step restoring divider for the mean.
// Reset clears the cells and sequence state and loads the register defaults.
// A result waiting on out_ready does not block the next segment; only a second
// result waiting behind it holds the sequencer. The config port is always ready.
module four_state_arc_viterbi_scorer #(
  parameter int MAX_SEGMENTS = fsavs_pkg::MAX_SEGMENTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        first_of_sequence,
  input  logic [31:0] seg_start_ms,
  input  logic [31:0] seg_end_ms,
  input  logic [12:0] context_score,
  input  logic [12:0] hook_score,
  input  logic [12:0] development_score,
  input  logic [12:0] resolution_score,
  input  logic [12:0] target_score,
  input  logic [12:0] bad_score,
  input  logic        viewer_cue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] arc_first_index,
  output logic [15:0] arc_last_index,
  output logic [31:0] arc_start_ms,
  output logic [31:0] arc_end_ms,
  output logic [12:0] arc_score,
  output logic        arc_has_cue,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  fsavs_pkg::cmd_t    cmd;
  fsavs_pkg::status_t status;

  assign cfg_ready = 1'b1;

  fsavs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  fsavs_dpath #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dpath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .first_of_sequence (first_of_sequence),
    .seg_start_ms      (seg_start_ms),
    .seg_end_ms        (seg_end_ms),
    .context_score     (context_score),
    .hook_score        (hook_score),
    .development_score (development_score),
    .resolution_score  (resolution_score),
    .target_score      (target_score),
    .bad_score         (bad_score),
    .viewer_cue        (viewer_cue),
    .arc_first_index   (arc_first_index),
    .arc_last_index    (arc_last_index),
    .arc_start_ms      (arc_start_ms),
    .arc_end_ms        (arc_end_ms),
    .arc_score         (arc_score),
    .arc_has_cue       (arc_has_cue)
  );

endmodule

[sv/fsavs_ctrl.sv]
// ----------------------------------------------------------------------------
// fsavs_ctrl
// Sequencer for one segment: emission pipe, state scan, check, divide, output.
// ----------------------------------------------------------------------------
module fsavs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output fsavs_pkg::cmd_t    cmd,
  input  fsavs_pkg::status_t status
);

  fsavs_pkg::state_t state, state_next;
  logic [3:0] cnt, cnt_next;
  logic       out_valid_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      fsavs_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = 4'd0;
          state_next = fsavs_pkg::S_EMIT;
        end
      end
      fsavs_pkg::S_EMIT: begin
        if (cnt == 4'd2) begin
          cnt_next   = 4'd0;
          state_next = fsavs_pkg::S_SCAN;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      fsavs_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        cmd.idx  = cnt[1:0];
        if (cnt == 4'd3) begin
          state_next = fsavs_pkg::S_COMMIT;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      fsavs_pkg::S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = fsavs_pkg::S_CHECK;
      end
      fsavs_pkg::S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = fsavs_pkg::S_TEST;
      end
      fsavs_pkg::S_TEST: begin
        cnt_next   = 4'd0;
        state_next = status.pass ? fsavs_pkg::S_DIV : fsavs_pkg::S_IDLE;
      end
      fsavs_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == 4'(fsavs_pkg::DIV_BITS - 1)) begin
          state_next = fsavs_pkg::S_FIN;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      fsavs_pkg::S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = fsavs_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = fsavs_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_next = (out_valid && !out_ready) || cmd.out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fsavs_pkg::S_IDLE;
      cnt       <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == fsavs_pkg::S_EMIT))
    else $error("accepted request did not start the emission pipe");

  a_div_needs_pass: assert property (@(posedge clk) disable iff (rst)
    (state == fsavs_pkg::S_DIV) |-> status.pass)
    else $error("divide running for a request that failed qualification");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

endmodule

[sv/fsavs_dpath.sv]
// ----------------------------------------------------------------------------
// fsavs_dpath
// Emission and gap pipes, four-cell max-sum update, qualification and divider.
// ----------------------------------------------------------------------------
module fsavs_dpath #(
  parameter int MAX_SEGMENTS = fsavs_pkg::MAX_SEGMENTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  fsavs_pkg::cmd_t    cmd,
  output fsavs_pkg::status_t status,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               first_of_sequence,
  input  logic [31:0]        seg_start_ms,
  input  logic [31:0]        seg_end_ms,
  input  logic [12:0]        context_score,
  input  logic [12:0]        hook_score,
  input  logic [12:0]        development_score,
  input  logic [12:0]        resolution_score,
  input  logic [12:0]        target_score,
  input  logic [12:0]        bad_score,
  input  logic               viewer_cue,
  output logic [15:0]        arc_first_index,
  output logic [15:0]        arc_last_index,
  output logic [31:0]        arc_start_ms,
  output logic [31:0]        arc_end_ms,
  output logic [12:0]        arc_score,
  output logic               arc_has_cue
);

  localparam int PW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int LW = PW + 1;
  localparam int CW = LW + 32;
  localparam int IW = PW + 16;

  // Configuration registers.
  logic [31:0] min_dur, max_dur;
  logic [12:0] min_mean;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_dur  <= fsavs_pkg::MIN_DUR_RST;
      max_dur  <= fsavs_pkg::MAX_DUR_RST;
      min_mean <= fsavs_pkg::MIN_MEAN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        fsavs_pkg::CFG_MIN_DUR:  min_dur  <= cfg_data;
        fsavs_pkg::CFG_MAX_DUR:  max_dur  <= cfg_data;
        fsavs_pkg::CFG_MIN_MEAN: min_mean <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Input holding registers.
  logic        first_r, cue_r;
  logic [31:0] st_r, en_r;
  logic [12:0] c_r, h_r, d_r, r_r, t_r, b_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      first_r <= first_of_sequence;
      st_r    <= seg_start_ms;
      en_r    <= seg_end_ms;
      c_r     <= context_score;
      h_r     <= hook_score;
      d_r     <= development_score;
      r_r     <= resolution_score;
      t_r     <= target_score;
      b_r     <= bad_score;
      cue_r   <= viewer_cue;
    end
  end

  // Sequence state.
  logic signed [31:0] cell_score [4];
  logic [PW-1:0]      cell_idx   [4];
  logic [31:0]        cell_ms    [4];
  logic [3:0]         cell_cue;
  logic [31:0]        prev_end;
  logic [PW-1:0]      position;
  logic               have_prev;

  logic          use_prev;
  logic [LW-1:0] pos1;
  logic [PW-1:0] pos_new;

  assign use_prev = !first_r && have_prev;
  assign pos1     = LW'(position) + LW'(1);
  assign pos_new  = (use_prev && (pos1 < LW'(MAX_SEGMENTS))) ? pos1[PW-1:0] : '0;

  // Emission: biased weighted sum, reciprocal multiply, one-step correction.
  logic signed [23:0] ce, he, de, re, te, be;
  logic signed [23:0] esum [4];
  logic [20:0] sum1 [4];
  logic [20:0] sum2 [4];
  logic [14:0] q0   [4];
  logic signed [15:0] emit [4];

  assign ce = $signed({11'b0, c_r});
  assign he = $signed({11'b0, h_r});
  assign de = $signed({11'b0, d_r});
  assign re = $signed({11'b0, r_r});
  assign te = $signed({11'b0, t_r});
  assign be = $signed({11'b0, b_r});

  always_comb begin
    esum[0] = 24'sd70 * ce + 24'sd16 * te - 24'sd50 * be + fsavs_pkg::EMIT_BIAS;
    esum[1] = 24'sd72 * he + 24'sd22 * ce + 24'sd18 * te - 24'sd46 * be
              + fsavs_pkg::EMIT_BIAS;
    esum[2] = 24'sd58 * de + 24'sd24 * te + 24'sd10 * he - 24'sd34 * be
              + fsavs_pkg::EMIT_BIAS;
    esum[3] = 24'sd70 * re + 24'sd12 * de + 24'sd12 * te - 24'sd42 * be
              + fsavs_pkg::EMIT_BIAS;
  end

  always_ff @(posedge clk) begin
    logic [36:0] prod;
    logic [21:0] erem;
    logic [14:0] qf;
    for (int s = 0; s < 4; s++) begin
      sum1[s] <= esum[s][20:0];
      prod     = 37'(sum1[s]) * 37'(fsavs_pkg::RECIP100);
      q0[s]   <= prod[36:22];
      sum2[s] <= sum1[s];
      erem     = 22'(sum2[s]) - 22'(q0[s]) * 22'd100;
      qf       = q0[s] + ((erem >= 22'd100) ? 15'd1 : 15'd0);
      emit[s] <= $signed({1'b0, qf}) - 16'sd8192;
    end
  end

  // Gap penalty: 0.055 per second of the whole gap once it passes 3.5 s, capped at 0.65.
  logic signed [32:0] gap;
  logic        act1, big1, act2, big2;
  logic [22:0] y1, y2;
  logic [11:0] pq0, pen;

  assign gap = $signed({1'b0, st_r}) - $signed({1'b0, prev_end});

  always_ff @(posedge clk) begin
    logic [45:0] pprod;
    logic [23:0] prem;
    logic [11:0] pq;
    act1  <= use_prev && (gap > 33'sd3500);
    big1  <= gap >= 33'sd11817;
    y1    <= 23'(gap[13:0]) * 23'd704;
    pprod  = 46'(y1) * 46'(fsavs_pkg::RECIP3125);
    pq0   <= pprod[45:34];
    y2    <= y1;
    act2  <= act1;
    big2  <= big1;
    prem   = 24'(y2) - 24'(pq0) * 24'd3125;
    pq     = pq0 + ((prem >= 24'd3125) ? 12'd1 : 12'd0);
    pen   <= !act2 ? 12'd0 : (big2 ? fsavs_pkg::PEN_CAP : pq);
  end

  // One state per scan step, four candidates; ties: new run, then lowest state.
  logic signed [12:0] pen_s;
  logic signed [34:0] cand [4];
  logic signed [34:0] best;
  logic [PW-1:0] bi;
  logic [31:0]   bm;
  logic          bc;
  logic signed [31:0] best_sat;

  assign pen_s = $signed({1'b0, pen});

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      cand[p] = 35'(cell_score[p]) + 35'(emit[cmd.idx])
                + 35'(fsavs_pkg::TRANS[p][cmd.idx]) - 35'(pen_s);
    end
    best = 35'(emit[cmd.idx]);
    bi   = pos_new;
    bm   = st_r;
    bc   = cue_r;
    if (use_prev) begin
      for (int p = 0; p < 4; p++) begin
        if (cand[p] > best) begin
          best = cand[p];
          bi   = cell_idx[p];
          bm   = cell_ms[p];
          bc   = cue_r | cell_cue[p];
        end
      end
    end
    if (best > 35'sd2147483647) begin
      best_sat = 32'sh7FFF_FFFF;
    end else if (best < -35'sd2147483648) begin
      best_sat = 32'sh8000_0000;
    end else begin
      best_sat = best[31:0];
    end
  end

  logic signed [31:0] n_score [4];
  logic [PW-1:0]      n_idx   [4];
  logic [31:0]        n_ms    [4];
  logic [3:0]         n_cue;

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      n_score[cmd.idx] <= best_sat;
      n_idx[cmd.idx]   <= bi;
      n_ms[cmd.idx]    <= bm;
      n_cue[cmd.idx]   <= bc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < 4; s++) begin
        cell_score[s] <= '0;
        cell_idx[s]   <= '0;
        cell_ms[s]    <= '0;
      end
      cell_cue  <= '0;
      prev_end  <= '0;
      position  <= '0;
      have_prev <= 1'b0;
    end else if (cmd.commit) begin
      for (int s = 0; s < 4; s++) begin
        cell_score[s] <= n_score[s];
        cell_idx[s]   <= n_idx[s];
        cell_ms[s]    <= n_ms[s];
      end
      cell_cue  <= n_cue;
      prev_end  <= en_r;
      position  <= pos_new;
      have_prev <= 1'b1;
    end
  end

  // Qualification: duration window and run length at commit, score next.
  logic [31:0]   dur;
  logic          dur_ok_c, dur_ok;
  logic [LW-1:0] len_c, len;
  logic [CW-1:0] min_prod, clamp_lim, sc_ext;
  logic          pass_q, clamp_q;

  assign dur      = en_r - n_ms[3];
  assign dur_ok_c = (en_r >= n_ms[3]) && (dur >= min_dur) && (dur <= max_dur);

  always_comb begin
    if (pos_new >= n_idx[3]) begin
      len_c = LW'(pos_new) - LW'(n_idx[3]) + LW'(1);
    end else begin
      len_c = LW'(pos_new) + LW'(MAX_SEGMENTS) - LW'(n_idx[3]) + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      dur_ok <= dur_ok_c;
      len    <= len_c;
    end
  end

  assign min_prod  = CW'(min_mean) * CW'(len);
  assign clamp_lim = (CW'(len) << 12) + CW'(len);
  assign sc_ext    = CW'(cell_score[3][30:0]);

  // Restoring divide, one quotient bit a step, for means below 4097.
  logic [31:0]   rem;
  logic [CW-1:0] dvs;
  logic [12:0]   quo;
  logic          take;

  assign take = CW'(rem) >= dvs;

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_q <= 1'b0;
    end else if (cmd.check) begin
      pass_q <= dur_ok && !cell_score[3][31] && (sc_ext >= min_prod);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      clamp_q <= sc_ext >= clamp_lim;
      rem     <= {1'b0, cell_score[3][30:0]};
      dvs     <= CW'(len) << (fsavs_pkg::DIV_BITS - 1);
      quo     <= '0;
    end else if (cmd.div_step) begin
      if (take) begin
        rem <= rem - dvs[31:0];
      end
      quo <= {quo[11:0], take};
      dvs <= dvs >> 1;
    end
  end

  assign status.pass = pass_q;

  // Result register.
  logic [IW-1:0] si_ext, pos_ext;

  assign si_ext  = IW'(cell_idx[3]);
  assign pos_ext = IW'(position);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      arc_first_index <= si_ext[15:0];
      arc_last_index  <= pos_ext[15:0];
      arc_start_ms    <= cell_ms[3];
      arc_end_ms      <= en_r;
      arc_score       <= clamp_q ? 13'd4096 : quo;
      arc_has_cue     <= cell_cue[3];
    end
  end

  a_commit_sets_prev: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> have_prev)
    else $error("commit left the sequence without previous cells");

  a_pen_capped: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> (pen <= fsavs_pkg::PEN_CAP))
    else $error("gap penalty above its cap during a scan");

  a_pass_needs_score: assert property (@(posedge clk) disable iff (rst)
    $rose(pass_q) |-> !cell_score[3][31])
    else $error("negative resolution score qualified");

endmodule

[tb/four_state_arc_viterbi_scorer_test.sv]
// ----------------------------------------------------------------------------
// four_state_arc_viterbi_scorer_test
// Drives transcript segments through the arc scorer in bursts and checks each
// arc against a Viterbi predictor kept in the bench, across several limits.
// ----------------------------------------------------------------------------
module four_state_arc_viterbi_scorer_test;

  typedef struct packed {
    logic        first;
    logic [31:0] st;
    logic [31:0] en;
    logic [12:0] c;
    logic [12:0] h;
    logic [12:0] d;
    logic [12:0] r;
    logic [12:0] t;
    logic [12:0] b;
    logic        cue;
  } segment_t;

  typedef struct packed {
    logic [15:0] first_idx;
    logic [15:0] last_idx;
    logic [31:0] start_ms;
    logic [31:0] end_ms;
    logic [12:0] score;
    logic        has_cue;
  } arc_t;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, in_ready;
  logic first_of_sequence = 0, viewer_cue = 0;
  logic [31:0] seg_start_ms = 0, seg_end_ms = 0;
  logic [12:0] context_score = 0, hook_score = 0, development_score = 0;
  logic [12:0] resolution_score = 0, target_score = 0, bad_score = 0;
  logic out_valid, out_ready = 0;
  logic [15:0] arc_first_index, arc_last_index;
  logic [31:0] arc_start_ms, arc_end_ms;
  logic [12:0] arc_score;
  logic arc_has_cue;
  logic cfg_valid = 0, cfg_ready;
  logic [1:0] cfg_index = fsavs_pkg::CFG_MIN_DUR;
  logic [31:0] cfg_data = 0;

  four_state_arc_viterbi_scorer uut (.*);

  // Predictor state.
  logic [31:0] lim_min_dur, lim_max_dur;
  logic [12:0] lim_min_mean;
  logic signed [31:0] p_score [4];
  logic [15:0] p_idx [4];
  logic [31:0] p_ms [4];
  logic p_cue [4];
  logic [31:0] p_prev_end;
  logic [15:0] p_pos;
  logic p_have;

  segment_t pending_segments[$];
  arc_t expected_arcs[$];
  int errors = 0;
  int cycles = 0;
  int burst_left = 0, gap_left = 0;
  bit stim_done = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint round_hundredths(longint v);
    longint x;
    x = v + 50;
    if (x >= 0) return x / 100;
    return -((-x + 99) / 100);
  endfunction

  // Advances the predicted cells by one segment and queues an arc if it qualifies.
  task automatic predict_arc(segment_t s);
    longint emit [4];
    longint pen, gap, best, cand, dur, len, sc, mean;
    logic signed [31:0] n_score [4];
    logic [15:0] n_idx [4];
    logic [31:0] n_ms [4];
    logic n_cue [4];
    logic [15:0] pos;
    logic [15:0] span;
    bit use_prev;
    arc_t a;
    use_prev = !s.first && p_have;
    pos = 0;
    pen = 0;
    if (use_prev) begin
      pos = p_pos + 16'd1;
      gap = longint'(s.st) - longint'(p_prev_end);
      if (gap > 3500) begin
        pen = (gap * 22528) / 100000;
        if (pen > 2662) pen = 2662;
      end
    end
    emit[0] = round_hundredths(70*longint'(s.c) + 16*longint'(s.t) - 50*longint'(s.b));
    emit[1] = round_hundredths(72*longint'(s.h) + 22*longint'(s.c) + 18*longint'(s.t)
                               - 46*longint'(s.b));
    emit[2] = round_hundredths(58*longint'(s.d) + 24*longint'(s.t) + 10*longint'(s.h)
                               - 34*longint'(s.b));
    emit[3] = round_hundredths(70*longint'(s.r) + 12*longint'(s.d) + 12*longint'(s.t)
                               - 42*longint'(s.b));
    for (int k = 0; k < 4; k++) begin
      best = emit[k];
      n_idx[k] = pos;
      n_ms[k] = s.st;
      n_cue[k] = s.cue;
      if (use_prev) begin
        for (int q = 0; q < 4; q++) begin
          cand = longint'(p_score[q]) + emit[k] + longint'(fsavs_pkg::TRANS[q][k]) - pen;
          if (cand > best) begin
            best = cand;
            n_idx[k] = p_idx[q];
            n_ms[k] = p_ms[q];
            n_cue[k] = s.cue | p_cue[q];
          end
        end
      end
      if (best > 64'sd2147483647) best = 64'sd2147483647;
      if (best < -64'sd2147483648) best = -64'sd2147483648;
      n_score[k] = best[31:0];
    end
    p_score = n_score;
    p_idx = n_idx;
    p_ms = n_ms;
    p_cue = n_cue;
    p_prev_end = s.en;
    p_pos = pos;
    p_have = 1;
    dur = longint'(s.en) - longint'(p_ms[3]);
    if (dur < longint'(lim_min_dur) || dur > longint'(lim_max_dur)) return;
    // The run length wraps with the 16-bit position counter.
    span = pos - p_idx[3];
    len = longint'(span) + 1;
    sc = p_score[3];
    if (sc < longint'(lim_min_mean) * len) return;
    mean = sc / len;
    if (mean < 0) mean = 0;
    if (mean > 4096) mean = 4096;
    a.first_idx = p_idx[3];
    a.last_idx = pos;
    a.start_ms = p_ms[3];
    a.end_ms = s.en;
    a.score = mean[12:0];
    a.has_cue = p_cue[3];
    expected_arcs.push_back(a);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic logic [12:0] rnd_feature();
    case ($urandom_range(0, 5))
      0: return 13'd0;
      1: return 13'd4096;
      2: return 13'($urandom);
      default: return 13'($urandom_range(0, 4096));
    endcase
  endfunction

  // A plausible arc: segments in increasing time with mostly small gaps.
  function automatic segment_t rnd_segment(bit first, logic [31:0] base);
    segment_t s;
    s.first = first;
    s.st = base + (($urandom_range(0, 4) == 0) ? $urandom_range(0, 30000)
                                               : $urandom_range(0, 800));
    s.en = s.st + $urandom_range(200, 6000);
    s.c = rnd_feature(); s.h = rnd_feature(); s.d = rnd_feature();
    s.r = rnd_feature(); s.t = rnd_feature();
    s.b = ($urandom_range(0, 2) == 0) ? rnd_feature() : 13'($urandom_range(0, 600));
    s.cue = $urandom_range(0, 3) == 0;
    return s;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      fsavs_pkg::CFG_MIN_DUR:  lim_min_dur = val;
      fsavs_pkg::CFG_MAX_DUR:  lim_max_dur = val;
      default:                 lim_min_mean = val[12:0];
    endcase
  endtask

  task automatic drain();
    while (pending_segments.size() != 0 || in_valid || expected_arcs.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Driver: bursts of requests separated by random gaps.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) predict_arc(segment_t'({first_of_sequence, seg_start_ms,
          seg_end_ms, context_score, hook_score, development_score, resolution_score,
          target_score, bad_score, viewer_cue}));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 0;
        end else if (pending_segments.size() != 0) begin
          segment_t s;
          s = pending_segments.pop_front();
          {first_of_sequence, seg_start_ms, seg_end_ms, context_score, hook_score,
           development_score, resolution_score, target_score, bad_score, viewer_cue} <= s;
          in_valid <= 1;
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
          end
        end else in_valid <= 0;
      end
    end
  end

  // Monitor and receiver stall pattern.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      out_ready <= (cycles % 256 < 80) ? 1'b1 : ($urandom_range(0, 2) != 0);
      if (out_valid && out_ready) begin
        if (expected_arcs.size() == 0) begin
          report_mismatch("unexpected arc at index", arc_last_index, -1);
        end else begin
          arc_t e;
          e = expected_arcs.pop_front();
          if (arc_first_index != e.first_idx)
            report_mismatch("arc_first_index", arc_first_index, e.first_idx);
          if (arc_last_index != e.last_idx)
            report_mismatch("arc_last_index", arc_last_index, e.last_idx);
          if (arc_start_ms != e.start_ms)
            report_mismatch("arc_start_ms", arc_start_ms, e.start_ms);
          if (arc_end_ms != e.end_ms) report_mismatch("arc_end_ms", arc_end_ms, e.end_ms);
          if (arc_score != e.score) report_mismatch("arc_score", arc_score, e.score);
          if (arc_has_cue != e.has_cue)
            report_mismatch("arc_has_cue", arc_has_cue, e.has_cue);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    segment_t s;
    logic [31:0] base;
    lim_min_dur = fsavs_pkg::MIN_DUR_RST;
    lim_max_dur = fsavs_pkg::MAX_DUR_RST;
    lim_min_mean = fsavs_pkg::MIN_MEAN_RST;
    for (int k = 0; k < 4; k++) begin
      p_score[k] = 0; p_idx[k] = 0; p_ms[k] = 0; p_cue[k] = 0;
    end
    p_prev_end = 0; p_pos = 0; p_have = 0;
    repeat (6) @(posedge clk);
    rst <= 0;

    // Directed: a first segment right after reset without the start flag,
    // extreme features, out-of-range features, gap penalty capped, times
    // running backward, and extreme times.
    s = '0; s.st = 32'd100; s.en = 32'd5000; s.r = 13'd4096; s.t = 13'd4096; s.cue = 1;
    pending_segments.push_back(s);
    s = '0; s.st = 32'd5000; s.en = 32'd9000; s.c = 13'd4096; s.h = 13'd4096;
    s.d = 13'd4096; s.r = 13'd4096; s.t = 13'd4096; pending_segments.push_back(s);
    s.b = 13'd4096; pending_segments.push_back(s);
    s = '1; s.first = 0; pending_segments.push_back(s);
    s = '0; s.st = 32'hFFFF_FFFF; s.en = 32'd0; s.r = 13'h1FFF; s.d = 13'h1FFF;
    pending_segments.push_back(s);
    s = '0; s.first = 1; s.st = 32'd0; s.en = 32'd1000; s.h = 13'd4096;
    pending_segments.push_back(s);
    s = '0; s.st = 32'd4501; s.en = 32'd6000; s.d = 13'd4096; pending_segments.push_back(s);
    s = '0; s.st = 32'd9500; s.en = 32'd12000; s.r = 13'd4096; pending_segments.push_back(s);
    s = '0; s.st = 32'd200000; s.en = 32'd201000; s.r = 13'd4096; s.cue = 1;
    pending_segments.push_back(s);
    s = '0; s.st = 32'd100; s.en = 32'd150; s.r = 13'd4096; pending_segments.push_back(s);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1: begin write_reg(fsavs_pkg::CFG_MIN_DUR, 32'd3000);
                 write_reg(fsavs_pkg::CFG_MAX_DUR, 32'd40000);
                 write_reg(fsavs_pkg::CFG_MIN_MEAN, 13'd900); end
        2: begin write_reg(fsavs_pkg::CFG_MIN_DUR, 32'd0);
                 write_reg(fsavs_pkg::CFG_MAX_DUR, 32'd0);
                 write_reg(fsavs_pkg::CFG_MIN_MEAN, 13'd0); end
        3: begin write_reg(fsavs_pkg::CFG_MIN_DUR, 32'hFFFF_FFFF);
                 write_reg(fsavs_pkg::CFG_MAX_DUR, 32'hFFFF_FFFF);
                 write_reg(fsavs_pkg::CFG_MIN_MEAN, 13'd4096); end
        4: begin write_reg(fsavs_pkg::CFG_MIN_DUR, $urandom_range(0, 20000));
                 write_reg(fsavs_pkg::CFG_MAX_DUR, $urandom);
                 write_reg(fsavs_pkg::CFG_MIN_MEAN, 13'h1FFF); end
        5: begin write_reg(fsavs_pkg::CFG_MIN_DUR, 32'd0);
                 write_reg(fsavs_pkg::CFG_MAX_DUR, 32'd60000);
                 write_reg(fsavs_pkg::CFG_MIN_MEAN, 13'($urandom_range(200, 1500))); end
        default: ;
      endcase
      base = $urandom;
      for (int n = 0; n < 240; n++) begin
        if ($urandom_range(0, 19) == 0) begin
          // Noise: unrelated times and arbitrary bits.
          s = segment_t'({$urandom, $urandom, $urandom, $urandom});
          s.first = $urandom_range(0, 7) == 0;
        end else begin
          s = rnd_segment($urandom_range(0, 14) == 0, base);
          base = s.en;
        end
        pending_segments.push_back(s);
      end
      drain();
    end

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
